@@ src/dlbm_pkg.sv @@
// dlbm_pkg: shared types and constants of the dual lfsr byte masker
// no dependencies; imported by every module under src

package dlbm_pkg;

  localparam int unsigned ShortBits = 16;
  localparam int unsigned LongBits  = 108;
  localparam int unsigned PosBits   = 32;
  localparam int unsigned CfgBits   = 32;

  // short register seed
  localparam logic [ShortBits-1:0] SHORT_SEED = 16'b1011010010101001;

  // long seed text, first character in the msb; only its first 108 characters are used
  localparam logic [117:0] LONG_SEED_TEXT = {
    59'b11111110011100100110000110010101000100100001011111111101010,
    59'b01010000000110001101111111011111011110010010000101111001101
  };
  localparam logic [LongBits-1:0] LONG_SEED = LONG_SEED_TEXT[117:10];

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SKIP_HEADER = 1'b0,
    REG_BYTE_LIMIT  = 1'b1
  } cfg_reg_e;

  // window settings handed to the position tracker
  typedef struct packed {
    logic               skip_header;
    logic [CfgBits-1:0] byte_limit;
  } window_cfg_t;

endpackage

@@ src/dlbm_keystream.sv @@
// dlbm_keystream: both lfsrs and the eight-step unrolled mask generator
// depends on dlbm_pkg

module dlbm_keystream (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       reload_i,   // start of file: work from the seeds
  input  logic       advance_i,  // masked byte leaves the stage
  output logic [7:0] mask_o
);
  import dlbm_pkg::*;

  logic [ShortBits-1:0] short_q, short_d;
  logic [LongBits-1:0]  long_q, long_d;

  always_comb begin
    logic [ShortBits-1:0] s;
    logic [LongBits-1:0]  l;
    logic                 os;
    logic                 ol;
    s = reload_i ? SHORT_SEED : short_q;
    l = reload_i ? LONG_SEED : long_q;
    mask_o = '0;
    for (int i = 0; i < 8; i++) begin
      os = s[0] ^ s[6];
      ol = l[0] ^ l[30];
      s = {os, s[ShortBits-1:1]};
      l = {ol, l[LongBits-1:1]};
      mask_o[7-i] = os ^ ol;
    end
    // seeds reload on start of file even when the byte is outside the window
    if (advance_i) begin
      short_d = s;
      long_d  = l;
    end else if (reload_i) begin
      short_d = SHORT_SEED;
      long_d  = LONG_SEED;
    end else begin
      short_d = short_q;
      long_d  = long_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= SHORT_SEED;
      long_q  <= LONG_SEED;
    end else begin
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

endmodule

@@ src/dlbm_window.sv @@
// dlbm_window: byte position counter and masking window compare
// depends on dlbm_pkg

module dlbm_window #(
  parameter int unsigned HEADER_BYTES = 100
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dlbm_pkg::window_cfg_t cfg_i,
  input  logic                 restart_i,  // start of file clears the position
  input  logic                 step_i,     // byte leaves the stage
  output logic                 inside_o
);
  import dlbm_pkg::*;

  localparam logic [PosBits-1:0] HeaderStart = PosBits'(HEADER_BYTES);
  localparam logic [PosBits-1:0] PosMax      = '1;

  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] pos_cur;
  logic [PosBits-1:0] start;

  always_comb begin
    pos_cur  = restart_i ? '0 : pos_q;
    start    = cfg_i.skip_header ? HeaderStart : PosBits'(1);
    inside_o = (pos_cur >= start) &&
               ((cfg_i.byte_limit == '0) || (pos_cur < cfg_i.byte_limit));
    pos_d = pos_q;
    if (step_i) begin
      // saturate at the top
      pos_d = (pos_cur == PosMax) ? pos_cur : pos_cur + PosBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ src/dual_lfsr_byte_masker_top.sv @@
// dual_lfsr_byte_masker_top: stream wrapper, config registers, input and result registers
// depends on dlbm_pkg, dlbm_keystream, dlbm_window
//
// channel   | direction | contents
// s_axis    | in        | tdata: data_byte[7:0]; tuser: start_of_file
// m_axis    | out       | tdata: data_out[7:0];  tuser: was_masked
// cfg       | in        | cfg_we_i, cfg_idx_i (0 skip_header, 1 byte_limit), cfg_data_i
//
// one byte per cycle sustained while m_axis_tready stays high
// the byte is registered, then the unrolled eight-step lfsr logic and window compare
// feed the result register while the lfsrs and position update in the same cycle
// reset loads both seeds, clears the position and both config registers
// stalls on m_axis back up through the ready chain; no transaction is dropped

module dual_lfsr_byte_masker_top #(
  parameter int unsigned HEADER_BYTES = 100
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]                   s_axis_tuser,   // [0] start_of_file
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [7:0] data_out
  output logic [0:0]                   m_axis_tuser,   // [0] was_masked
  // config write port
  input  logic                         cfg_we_i,
  input  dlbm_pkg::cfg_reg_e           cfg_idx_i,
  input  logic [dlbm_pkg::CfgBits-1:0] cfg_data_i
);
  import dlbm_pkg::*;

  // config registers
  window_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SKIP_HEADER: cfg_q.skip_header <= cfg_data_i[0];
        REG_BYTE_LIMIT:  cfg_q.byte_limit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_sof_q;
  // result register
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_masked_q;

  logic out_ready;   // result register can take a new value
  logic fire;        // byte moves from input register to result register
  logic in_window;
  logic [7:0] mask;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_sof_q  <= s_axis_tuser[0];
    end
  end

  dlbm_keystream u_keystream (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .reload_i  (fire && in_sof_q),
    .advance_i (fire && in_window),
    .mask_o    (mask)
  );

  dlbm_window #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (in_sof_q),
    .step_i    (fire),
    .inside_o  (in_window)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q   <= in_window ? (in_data_q ^ mask) : in_data_q;
      out_masked_q <= in_window;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_masked_q;

  // empty input register always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  // an unmasked byte passes through unchanged
  a_unmasked_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !in_window) |=> (m_axis_tdata == $past(in_data_q)) && !m_axis_tuser[0])
    else $error("unmasked byte altered");

  // a result only appears after the input register held a byte
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without a byte");

endmodule

@@ dv/testbench.sv @@
// testbench for dual_lfsr_byte_masker_top: streams files of random bytes through the masker
// and checks every result against a keystream predictor kept in step with the accepted input
// depends on dlbm_pkg and dual_lfsr_byte_masker_top under src

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dlbm_pkg::*;

  localparam int unsigned HeaderBytes = 100;

  // one byte as handed to the slave stream
  typedef struct packed {
    logic [7:0] data;
    logic       sof;
  } file_byte_t;

  // one result as seen on the master stream
  typedef struct packed {
    logic [7:0] data;
    logic       masked;
  } masked_byte_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  // block ports, all inputs known from time zero
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  cfg_reg_e            cfg_idx_i     = REG_SKIP_HEADER;
  logic [CfgBits-1:0]  cfg_data_i    = '0;

  dual_lfsr_byte_masker_top #(
    .HEADER_BYTES(HeaderBytes)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tuser  (s_axis_tuser),   // [0] start_of_file
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] data_out
    .m_axis_tuser  (m_axis_tuser),   // [0] was_masked
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // keystream predictor state, a private copy of what the block should hold
  // ---------------------------------------------------------------------------

  // first character is bit 107 of the long register
  string long_seed_txt = {
    "11111110011100100110000110010101000100100001011111111101010",
    "01010000000110001101111111011111011110010010000101111001101"
  };

  logic [15:0]  short_lfsr;
  logic [107:0] long_lfsr;
  logic [31:0]  next_pos;          // position of the next byte
  logic         cfg_skip_header;
  logic [31:0]  cfg_byte_limit;

  file_byte_t   pending_bytes[$];  // bytes waiting for the driver
  masked_byte_t expected_bytes[$]; // predicted results, oldest first

  int  mismatch_count = 0;
  bit  idle_on        = 1'b0;      // random idling on both streams
  int  src_gap        = 0;
  int  sink_gap       = 0;

  function automatic void reload_seeds();
    short_lfsr = 16'hB4A9;
    for (int k = 0; k < 108; k++) begin
      long_lfsr[107-k] = (long_seed_txt[k] == "1");
    end
  endfunction

  // works out the result of one accepted byte and advances the predictor
  function automatic masked_byte_t mask_next_byte(input file_byte_t fb);
    masked_byte_t res;
    logic [31:0]  win_start;
    logic         s_out;
    logic         l_out;
    logic [7:0]   key;
    if (fb.sof) begin
      reload_seeds();
      next_pos = '0;
    end
    win_start  = cfg_skip_header ? 32'(HeaderBytes) : 32'd1;
    res.masked = (next_pos >= win_start) &&
                 (cfg_byte_limit == '0 || next_pos < cfg_byte_limit);
    key = '0;
    if (res.masked) begin
      // eight steps of both registers, first keystream bit into the msb
      for (int i = 0; i < 8; i++) begin
        s_out        = short_lfsr[0] ^ short_lfsr[6];
        short_lfsr   = {s_out, short_lfsr[15:1]};
        l_out        = long_lfsr[0] ^ long_lfsr[30];
        long_lfsr    = {l_out, long_lfsr[107:1]};
        key[7-i]     = s_out ^ l_out;
      end
    end
    res.data = fb.data ^ key;
    // the position saturates instead of wrapping
    if (next_pos != 32'hFFFF_FFFF) next_pos = next_pos + 32'd1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: slave stream, fed from pending_bytes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic       nxt_valid;
    logic [7:0] nxt_data;
    logic [0:0] nxt_user;
    file_byte_t fb;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    nxt_user  = s_axis_tuser;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else begin
      // a transaction completes here: predict its result
      if (s_axis_tvalid && s_axis_tready) begin
        fb.data = s_axis_tdata;
        fb.sof  = s_axis_tuser[0];
        expected_bytes.push_back(mask_next_byte(fb));
        nxt_valid = 1'b0;
      end
      // the bus is free: idle a while or present the next byte
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 19) - 1;
        end else if (pending_bytes.size() > 0) begin
          fb        = pending_bytes.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = fb.data;
          nxt_user  = fb.sof;
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
    s_axis_tuser  <= nxt_user;
  end

  // ---------------------------------------------------------------------------
  // monitor: master stream, compares each transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    masked_byte_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result data %02h masked %b", $realtime,
                     m_axis_tdata, m_axis_tuser[0]);
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tuser[0] !== want.masked) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch data %02h masked %b, expected data %02h masked %b",
                       $realtime, m_axis_tdata, m_axis_tuser[0], want.data, want.masked);
          end
        end
      end
      // receiver stalls in bursts
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_byte(input logic [7:0] data, input logic sof);
    file_byte_t fb;
    fb.data = data;
    fb.sof  = sof;
    pending_bytes.push_back(fb);
  endfunction

  // waits until every queued byte is sent and every predicted result is checked
  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    // only the low bit of the header flag is kept
    if (idx == REG_SKIP_HEADER) cfg_skip_header = value[0];
    else cfg_byte_limit = value;
  endtask

  // both registers, the header flag with random upper bits
  task automatic set_window(input logic mh, input logic [31:0] limit);
    drain();
    write_cfg(REG_SKIP_HEADER, {31'($urandom() >> 1), mh});
    write_cfg(REG_BYTE_LIMIT, limit);
  endtask

  // random files: mostly well-formed, starting with a start mark, some just continuing
  task automatic queue_files(input int n_items);
    int queued;
    int len;
    queued = 0;
    while (queued < n_items) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 250);
      if (len > n_items - queued) len = n_items - queued;
      for (int i = 0; i < len; i++) begin
        queue_byte(8'($urandom()), (i == 0) && ($urandom_range(0, 15) != 0));
      end
      queued += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] lim;
    reload_seeds();
    next_pos        = '0;
    cfg_skip_header = 1'b0;
    cfg_byte_limit  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset window, bytes before any start mark, extremes of the data
    idle_on = 1'b0;
    queue_byte(8'h00, 1'b0);  // position zero lies outside the window
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFF, 1'b1);  // start mark mid stream reloads the seeds
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);

    // limit at the window start: nothing masked
    set_window(1'b0, 32'd1);
    queue_byte(8'h12, 1'b1);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h56, 1'b0);

    // short window, positions one and two only
    set_window(1'b0, 32'd3);
    for (int i = 0; i < 4; i++) queue_byte(8'hFF, i == 0);

    // header masking, short file never reaches the window
    set_window(1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) queue_byte(8'($urandom()), i == 0);

    // random phases over a spread of window settings
    set_window(1'b0, 32'd0);
    idle_on = ($urandom_range(0, 3) != 0);
    queue_files(180);

    set_window(1'b1, 32'd0);
    idle_on = ($urandom_range(0, 3) != 0);
    queue_files(180);

    // limit equal to the header start: nothing masked
    set_window(1'b1, 32'(HeaderBytes));
    idle_on = 1'b1;
    queue_files(180);

    set_window(1'b1, 32'(HeaderBytes) + 32'd1);
    idle_on = 1'b1;
    queue_files(180);

    set_window(1'b1, 32'hFFFF_FFFF);
    idle_on = ($urandom_range(0, 3) != 0);
    queue_files(180);

    lim = $urandom() | 32'h8000_0000;
    set_window(1'b0, lim);
    idle_on = 1'b1;
    queue_files(180);

    set_window(1'b0, 32'($urandom_range(2, 200)));
    idle_on = 1'b1;
    queue_files(180);

    set_window(1'b1, 32'($urandom_range(HeaderBytes, 350)));
    idle_on = 1'b1;
    queue_files(180);

    // closing stretch at full rate, no idling on either side
    set_window(1'b0, 32'd0);
    idle_on = 1'b0;
    queue_files(180);

    drain();
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #12ms;
    $display("testbench failed");
    $finish;
  end

endmodule
